/* design/dwm_pkg.sv */
// shared types and constants for the deferred write data memory port
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package dwm_pkg;

  localparam int MEM_DEPTH     = 4096;
  localparam int ADDR_W        = $clog2(MEM_DEPTH);
  localparam int MAX_UNITS     = 8;
  localparam int CNT_W         = 4;
  localparam int QUEUE_DEPTH   = 8;
  localparam int QIDX_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_UNIT_BITS = 32;
  localparam int UBITS_W       = 6;
  localparam int WORD_W        = 64;
  localparam int SH_W          = 9;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_DEFER  = 2'd1,
    CMD_DIRECT = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_LE    = 2'd0;
  localparam logic [1:0] REG_FIRST = 2'd1;
  localparam logic [1:0] REG_LAST  = 2'd2;
  localparam logic [1:0] REG_UBITS = 2'd3;

  typedef struct packed {
    cmd_e                cmd;
    logic [ADDR_W-1:0]   address;
    logic [CNT_W-1:0]    unit_count;
    logic [WORD_W-1:0]   write_data;
    logic                range_err;
  } item_t;

  typedef struct packed {
    logic                little_endian;
    logic [11:0]         first_address;
    logic [11:0]         last_address;
    logic [UBITS_W-1:0]  bits;
  } cfg_t;

  // one access as the back end walks it
  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [CNT_W-1:0]    len;
    logic [WORD_W-1:0]   word;
    logic [UBITS_W-1:0]  bits;
    logic                le;
  } entry_t;

  typedef struct packed {
    logic                clearing;
    logic [QCNT_W-1:0]   pcount;
  } back_stat_t;

endpackage

/* design/deferred_write_data_memory_port.sv */
// Data memory port with configurable unit width and endianness.
// Input channel (in_valid / in_stall) carries one command word: read,
// deferred write, direct write or commit tick. Output channel
// (out_valid / out_stall) returns exactly one word per command: read_data
// and status (ok, address range error, write queue full).
// A front end range checks each word and places it in a two entry queue;
// the back end owns the 4096 unit store and an 8 entry pending write queue.
// A tick walks every unit of every pending entry, one unit written per cycle,
// set by the single store write port. The back end starts a command only once
// the previous result is taken, so a stalled receiver holds the back end while
// the front queue keeps filling. After reset the store is cleared, one unit per
// cycle, with in_stall high; configuration writes over the APB port are taken
// at any time.
// depends on dwm_pkg, dwm_front, dwm_back
`timescale 1ns / 1ps

module deferred_write_data_memory_port import dwm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   cmd,
  input  logic [11:0]  address,
  input  logic [3:0]   unit_count,
  input  logic [63:0]  write_data,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [63:0]  read_data,
  output logic [1:0]   status,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic               little_endian;
  logic [11:0]        first_address;
  logic [11:0]        last_address;
  logic [5:0]         unit_bits;
  cfg_t               cfg;
  logic               item_valid;
  logic               item_ready;
  item_t              item;
  back_stat_t         stat;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      little_endian <= 1'b0;
      first_address <= 12'd0;
      last_address  <= 12'd4095;
      unit_bits     <= 6'd8;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_LE:    little_endian <= pwdata[0];
        REG_FIRST: first_address <= pwdata[11:0];
        REG_LAST:  last_address  <= pwdata[11:0];
        REG_UBITS: unit_bits     <= pwdata[5:0];
        default:   ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_LE:    prdata = {31'd0, little_endian};
      REG_FIRST: prdata = {20'd0, first_address};
      REG_LAST:  prdata = {20'd0, last_address};
      REG_UBITS: prdata = {26'd0, unit_bits};
      default:   prdata = 32'd0;
    endcase
  end

  // effective unit width, clamped to 1..MAX_UNIT_BITS
  always_comb begin
    cfg.little_endian = little_endian;
    cfg.first_address = first_address;
    cfg.last_address  = last_address;
    if (unit_bits == 6'd0) cfg.bits = 6'd1;
    else if (unit_bits > 6'(MAX_UNIT_BITS)) cfg.bits = 6'(MAX_UNIT_BITS);
    else cfg.bits = unit_bits;
  end

  dwm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .hold       (stat.clearing),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .address    (address),
    .unit_count (unit_count),
    .write_data (write_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  dwm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (read_data),
    .out_status (status),
    .stat       (stat)
  );

  // checks
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    stat.clearing |-> in_stall) else $error("word accepted during store clear");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    stat.pcount <= QCNT_W'(QUEUE_DEPTH)) else $error("pending queue overrun");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_RANGE || status == ST_FULL))
    else $error("bad status code");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (read_data == 64'd0))
    else $error("refused word carries data");

endmodule

/* design/dwm_front.sv */
// front end: accepts words, range checks them and holds them in a short queue
// depends on dwm_pkg
`timescale 1ns / 1ps

module dwm_front import dwm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                hold,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  logic [11:0]         address,
  input  logic [3:0]          unit_count,
  input  logic [63:0]         write_data,
  output logic                item_valid,
  input  logic                item_ready,
  output item_t               item
);

  item_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic [12:0] last_unit;
  logic        bad;
  logic        push;
  logic        pop;

  // window check on the incoming word
  always_comb begin
    last_unit = {1'b0, address} + {9'b0, unit_count} - 13'd1;
    bad = (unit_count == 4'd0) || (unit_count > 4'(MAX_UNITS)) ||
          (address < cfg.first_address) || (last_unit > {1'b0, cfg.last_address}) ||
          (last_unit >= 13'(MEM_DEPTH));
  end

  assign in_stall   = hold || (fill == 2'd2);
  assign push       = in_valid && !in_stall;
  assign item_valid = (fill != 2'd0);
  assign pop        = item_valid && item_ready;
  assign item       = slot[rd_ptr];

  // two entry queue toward the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= '{cmd: cmd_e'(cmd), address: address, unit_count: unit_count,
                          write_data: write_data, range_err: bad};
        wr_ptr <= !wr_ptr;
      end
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* design/dwm_back.sv */
// back end: unit store, pending write queue and the sequencer that walks units
// depends on dwm_pkg
`timescale 1ns / 1ps

module dwm_back import dwm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                item_valid,
  output logic                item_ready,
  input  item_t               item,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [WORD_W-1:0]   out_data,
  output logic [1:0]          out_status,
  output back_stat_t          stat
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_WRITE, S_TICK} state_t;

  state_t             state;
  entry_t             cur;
  entry_t             pend [QUEUE_DEPTH];
  entry_t             act;
  logic [QIDX_W-1:0]  q;
  logic [QCNT_W-1:0]  pcount;
  logic [CNT_W-1:0]   k;
  logic [SH_W-1:0]    s;
  logic [WORD_W-1:0]  acc;
  logic [WORD_W-1:0]  acc_next;
  logic               rd_pend;
  logic [SH_W-1:0]    rd_shift;
  logic [ADDR_W-1:0]  clr_addr;

  logic [31:0]        mem [MEM_DEPTH];
  logic [31:0]        rdata;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [31:0]        wdata;
  logic [ADDR_W-1:0]  uaddr;
  logic [CNT_W-1:0]   off;
  logic [WORD_W-1:0]  shifted;
  logic [31:0]        umask;
  logic [31:0]        unit_val;
  logic               last_unit;
  logic [WORD_W-1:0]  contrib;

  // current access: a queue entry during commit, else the latched item
  always_comb begin
    act       = (state == S_TICK) ? pend[q] : cur;
    off       = act.le ? k : (act.len - 4'd1 - k);
    uaddr     = act.addr + {{(ADDR_W-CNT_W){1'b0}}, off};
    last_unit = (k == act.len - 4'd1);
    shifted   = act.word >> s[5:0];
    umask     = (act.bits >= 6'(MAX_UNIT_BITS)) ? 32'hFFFF_FFFF
                : ((32'd1 << act.bits) - 32'd1);
    unit_val  = (s[SH_W-1:6] == '0) ? (shifted[31:0] & umask) : 32'd0;
    contrib   = (rd_shift[SH_W-1:6] == '0) ? ({32'd0, rdata} << rd_shift[5:0]) : '0;
    acc_next  = rd_pend ? (acc | contrib) : acc;
  end

  // memory port selection
  always_comb begin
    we    = (state == S_CLEAR) || (state == S_WRITE) || (state == S_TICK);
    waddr = (state == S_CLEAR) ? clr_addr : uaddr;
    wdata = (state == S_CLEAR) ? 32'd0 : unit_val;
  end

  // unit store, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[uaddr];
  end

  assign item_ready    = (state == S_IDLE) && !out_valid;
  assign stat.clearing = (state == S_CLEAR);
  assign stat.pcount   = pcount;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      pcount    <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
      q         <= '0;
      k         <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          k        <= '0;
          s        <= '0;
          q        <= '0;
          acc      <= '0;
          rd_pend  <= 1'b0;
          cur      <= '{addr: item.address, len: item.unit_count, word: item.write_data,
                        bits: cfg.bits, le: cfg.little_endian};
          if (item_valid && item_ready) begin
            out_data <= '0;
            if (item.cmd == CMD_TICK) begin
              if (pcount == '0) begin
                out_status <= ST_OK;
                out_valid  <= 1'b1;
              end else begin
                state <= S_TICK;
              end
            end else if (item.range_err) begin
              out_status <= ST_RANGE;
              out_valid  <= 1'b1;
            end else begin
              case (item.cmd)
                CMD_READ:   state <= S_READ;
                CMD_DIRECT: state <= S_WRITE;
                default: begin
                  if (pcount == QCNT_W'(QUEUE_DEPTH)) begin
                    out_status <= ST_FULL;
                  end else begin
                    pend[pcount[QIDX_W-1:0]] <= '{addr: item.address, len: item.unit_count,
                                                 word: item.write_data, bits: cfg.bits,
                                                 le: cfg.little_endian};
                    pcount     <= pcount + 1'b1;
                    out_status <= ST_OK;
                  end
                  out_valid <= 1'b1;
                end
              endcase
            end
          end
        end
        S_READ: begin
          acc <= acc_next;
          if (k != act.len) begin
            rd_pend  <= 1'b1;
            rd_shift <= s;
            k        <= k + 1'b1;
            s        <= s + SH_W'(act.bits);
          end else begin
            rd_pend    <= 1'b0;
            out_data   <= acc_next;
            out_status <= ST_OK;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_WRITE: begin
          k <= k + 1'b1;
          s <= s + SH_W'(act.bits);
          if (last_unit) begin
            out_status <= ST_OK;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_TICK: begin
          if (last_unit) begin
            k <= '0;
            s <= '0;
            if (QCNT_W'(q) + 1'b1 == pcount) begin
              pcount     <= '0;
              out_status <= ST_OK;
              out_valid  <= 1'b1;
              state      <= S_IDLE;
            end else begin
              q <= q + 1'b1;
            end
          end else begin
            k <= k + 1'b1;
            s <= s + SH_W'(act.bits);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* bench/deferred_write_data_memory_port_test.sv */
// self-checking bench for deferred_write_data_memory_port: random and directed
// commands, a predictor of the unit store and pending queue, and an in-order checker
// depends on dwm_pkg and the deferred_write_data_memory_port rtl
`timescale 1ns / 1ps

module deferred_write_data_memory_port_test;
  import dwm_pkg::*;

  typedef struct {
    cmd_e        cmd;
    logic [11:0] addr;
    logic [3:0]  cnt;
    logic [63:0] data;
  } mem_req_t;

  typedef struct {
    logic [63:0] rdata;
    logic [1:0]  status;
  } mem_resp_t;

  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = '0;
  logic [11:0] address = '0;
  logic [3:0]  unit_count = '0;
  logic [63:0] write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] read_data;
  logic [1:0]  status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic        cfg_le = 1'b0;
  logic [11:0] cfg_first = 12'd0;
  logic [11:0] cfg_last = 12'd4095;
  logic [5:0]  cfg_ubits = 6'd8;
  logic [31:0] unit_mem [MEM_DEPTH];
  logic [11:0] wq_addr [QUEUE_DEPTH];
  logic [3:0]  wq_len [QUEUE_DEPTH];
  logic [31:0] wq_units [QUEUE_DEPTH][MAX_UNITS];
  int          wq_count = 0;

  mem_req_t  req_queue[$];
  mem_resp_t expected_results[$];
  int        errors = 0;
  int        idle_cycles = 0;
  int        send_gap = 0;
  int        stall_left = 0;

  deferred_write_data_memory_port dut (.*);

  always #1 clk = ~clk;

  initial begin
    for (int k = 0; k < MEM_DEPTH; k++) unit_mem[k] = '0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // bit offset of unit i in the packed word
  function automatic int unit_pos(int i, int n, int bits);
    return cfg_le ? i * bits : (n - 1 - i) * bits;
  endfunction

  // apply one command to the predicted memory and return its response
  function automatic mem_resp_t model_access(mem_req_t r);
    mem_resp_t   res;
    int          bits, s, last_unit;
    logic [31:0] m;
    logic [31:0] u [MAX_UNITS];
    bit          ok;
    res.rdata = '0;
    res.status = ST_OK;
    bits = (cfg_ubits == 0) ? 1 : (cfg_ubits > MAX_UNIT_BITS) ? MAX_UNIT_BITS : cfg_ubits;
    m = (bits >= 32) ? 32'hffff_ffff : (32'h1 << bits) - 1;
    last_unit = int'(r.addr) + int'(r.cnt) - 1;
    ok = r.cnt != 0 && r.cnt <= MAX_UNITS && r.addr >= cfg_first
         && last_unit <= int'(cfg_last) && last_unit < MEM_DEPTH;
    // split the word per current width and endianness
    for (int i = 0; i < MAX_UNITS; i++) begin
      s = unit_pos(i, r.cnt, bits);
      u[i] = (i < r.cnt && s < 64) ? 32'(r.data >> s) & m : 32'h0;
    end
    if (r.cmd == CMD_TICK) begin
      for (int q = 0; q < wq_count; q++)
        for (int i = 0; i < wq_len[q]; i++)
          unit_mem[(wq_addr[q] + i) % MEM_DEPTH] = wq_units[q][i];
      wq_count = 0;
    end else if (!ok) begin
      res.status = ST_RANGE;
    end else if (r.cmd == CMD_READ) begin
      for (int i = 0; i < r.cnt; i++) begin
        s = unit_pos(i, r.cnt, bits);
        if (s < 64) res.rdata |= {32'h0, unit_mem[r.addr + i]} << s;
      end
    end else if (r.cmd == CMD_DIRECT) begin
      for (int i = 0; i < r.cnt; i++) unit_mem[r.addr + i] = u[i];
    end else if (wq_count >= QUEUE_DEPTH) begin
      res.status = ST_FULL;
    end else begin
      wq_addr[wq_count] = r.addr;
      wq_len[wq_count] = r.cnt;
      for (int i = 0; i < MAX_UNITS; i++) wq_units[wq_count][i] = u[i];
      wq_count++;
    end
    return res;
  endfunction

  // register write: setup cycle then access cycle
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LE:    cfg_le = val[0];
      REG_FIRST: cfg_first = val[11:0];
      REG_LAST:  cfg_last = val[11:0];
      REG_UBITS: cfg_ubits = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic le, logic [11:0] lo, logic [11:0] hi, logic [5:0] ub);
    reg_write(REG_LE, {31'h0, le});
    reg_write(REG_FIRST, {20'h0, lo});
    reg_write(REG_LAST, {20'h0, hi});
    reg_write(REG_UBITS, {26'h0, ub});
  endtask

  task automatic push_req(cmd_e c, int a, int n, logic [63:0] d);
    mem_req_t r;
    r.cmd = c;
    r.addr = a[11:0];
    r.cnt = n[3:0];
    r.data = d;
    req_queue = {req_queue, r};
  endtask

  // random command, mostly in the window and near its start so reads hit writes
  task automatic push_random();
    int   rc, n, a, span;
    cmd_e c;
    rc = $urandom_range(0, 99);
    c = (rc < 35) ? CMD_READ : (rc < 65) ? CMD_DEFER : (rc < 90) ? CMD_DIRECT : CMD_TICK;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, MAX_UNITS);
    if ($urandom_range(0, 9) == 0 || cfg_first > cfg_last) begin
      a = $urandom_range(0, 4095);
    end else begin
      span = int'(cfg_last) - int'(cfg_first);
      if (span > 40) span = 40;
      a = int'(cfg_first) + $urandom_range(0, span);
    end
    push_req(c, a, n, {$urandom(), $urandom()});
  endtask

  // wait until every queued command has produced its response, then let the back end drain
  task automatic wait_idle();
    while (req_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // stimulus
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // directed words under reset settings
    push_req(CMD_DIRECT, 0, 8, 64'hffff_ffff_ffff_ffff);
    push_req(CMD_READ, 0, 8, 64'h0);
    push_req(CMD_DIRECT, 8, 8, 64'h0123_4567_89ab_cdef);
    push_req(CMD_READ, 8, 8, 64'h0);
    push_req(CMD_READ, 4, 3, 64'h0);
    push_req(CMD_READ, 0, 0, 64'h0);
    push_req(CMD_READ, 0, 15, 64'h0);
    push_req(CMD_DIRECT, 4095, 1, 64'h0000_0000_0000_00a5);
    push_req(CMD_READ, 4095, 1, 64'h0);
    push_req(CMD_READ, 4094, 4, 64'h0);
    push_req(CMD_TICK, 0, 1, 64'h0);
    for (int i = 0; i < 9; i++) push_req(CMD_DEFER, 16 + i, 2, {$urandom(), $urandom()});
    push_req(CMD_DEFER, 4095, 2, 64'h0);
    push_req(CMD_TICK, 0, 1, 64'h0);
    push_req(CMD_READ, 16, 8, 64'h0);
    push_req(CMD_DIRECT, 0, 8, 64'h0);
    wait_idle();
    // random phases across settings, extremes included
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: set_config(1'b1, 12'd0, 12'd4095, 6'd32);
        1: set_config(1'b0, 12'd100, 12'd200, 6'd63);
        2: set_config(1'b1, 12'd16, 12'd31, 6'd0);
        3: set_config(1'b0, 12'd300, 12'd200, 6'd5);
        4: set_config(1'b1, 12'd4095, 12'd4095, 6'd12);
        5: set_config(1'b0, 12'd4088, 12'd4095, 6'd1);
        default: set_config(1'b0, 12'd0, 12'd4095, 6'd13);
      endcase
      for (int i = 0; i < 76; i++) push_random();
      wait_idle();
    end
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // driver: presents one command word at a time with random gaps
  always @(posedge clk) begin
    mem_req_t r;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        r.cmd = cmd_e'(cmd);
        r.addr = address;
        r.cnt = unit_count;
        r.data = write_data;
        expected_results = {expected_results, model_access(r)};
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (req_queue.size() != 0) begin
          r = req_queue.pop_front();
          in_valid <= 1'b1;
          cmd <= r.cmd;
          address <= r.addr;
          unit_count <= r.cnt;
          write_data <= r.data;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back pressure and in-order response check
  always @(posedge clk) begin
    mem_resp_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected word: read_data %h status %0d", read_data, status);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (read_data !== e.rdata) begin
            $error("read_data expected %h actual %h", e.rdata, read_data);
            errors++;
          end
          if (status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, status);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < 60) begin
        out_stall <= 1'b0;
      end else begin
        stall_left <= pick_gap();
        out_stall <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no accepted word on either side and no register access
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

/* deferred_write_data_memory_port.f */
design/dwm_pkg.sv
design/dwm_front.sv
design/dwm_back.sv
design/deferred_write_data_memory_port.sv
bench/deferred_write_data_memory_port_test.sv
